// ----- rtl/ftp_pkg.sv -----
// ----------------------------------------------------------------------------
// ftp_pkg
// Shared types and constants for the flagged transport header parser.
// ----------------------------------------------------------------------------
package ftp_pkg;

   localparam int RSP_DEPTH_DEFAULT = 4;

   // record kinds
   localparam logic [1:0] KIND_SUMMARY = 2'd0;
   localparam logic [1:0] KIND_OPTION  = 2'd1;
   localparam logic [1:0] KIND_OTHER   = 2'd2;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [31:0] header_word;
      logic [31:0] dest_flow;
      logic [31:0] source_flow;
      logic [31:0] sequence_value;
      logic [31:0] ack_value;
      logic [31:0] max_segment;
      logic [31:0] fragment_word;
      logic [31:0] option_word;
      logic [6:0]  present_mask;
      logic        last_of_run;
   } rsp_rec_type;

   // what one parsed byte produces: zero, one or two records
   typedef struct packed {
      logic [1:0]  count;
      rsp_rec_type rec0;
      rsp_rec_type rec1;
   } step_out_type;

endpackage

// ----- rtl/flagged_transport_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// flagged_transport_header_parser_unit
// Byte-serial parser for a flagged transport header with option records.
// ----------------------------------------------------------------------------
// path: a byte waits in the item register; its records go to the queue
// throughput: one byte per cycle; a byte that yields two records pushes one
//   extra record, drained by the result queue; a held item stalls the
//   input while the queue has fewer than two free entries
// reset: synchronous, active high; parse state returns to idle, queue empties
module flagged_transport_header_parser_unit #(
   parameter int RSP_DEPTH = ftp_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_packet,
   input  logic        req_end_of_packet,
   input  logic [15:0] req_packet_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_kind,
   output logic [31:0] rsp_header_word,
   output logic [31:0] rsp_dest_flow,
   output logic [31:0] rsp_source_flow,
   output logic [31:0] rsp_sequence_value,
   output logic [31:0] rsp_ack_value,
   output logic [31:0] rsp_max_segment,
   output logic [31:0] rsp_fragment_word,
   output logic [31:0] rsp_option_word,
   output logic [6:0]  rsp_present_mask,
   output logic        rsp_last_of_run
);
   import ftp_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        in_sop_ff;
   logic        in_eop_ff;
   logic [15:0] in_len_ff;
   logic        step;
   logic        room2;
   logic        not_empty;
   logic [$clog2(RSP_DEPTH+1)-1:0] level;
   step_out_type step_out;
   rsp_rec_type  head;

   // item register; drained whenever the queue has room for two records
   assign step      = in_vld_ff && room2;
   assign req_ready = !in_vld_ff || room2;
   assign in_vld_in = (req_valid && req_ready) ? 1'b1 : (step ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_sop_ff  <= req_start_of_packet;
         in_eop_ff  <= req_end_of_packet;
         in_len_ff  <= req_packet_length;
      end
   end

   ftp_parse_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step_en         (step),
      .data_byte       (in_byte_ff),
      .start_of_packet (in_sop_ff),
      .end_of_packet   (in_eop_ff),
      .packet_length   (in_len_ff),
      .step_out        (step_out)
   );

   ftp_rsp_queue #(.DEPTH(RSP_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_out),
      .pop       (rsp_valid && rsp_ready),
      .head      (head),
      .not_empty (not_empty),
      .room2     (room2),
      .level     (level)
   );

   assign rsp_valid          = not_empty;
   assign rsp_record_kind    = head.record_kind;
   assign rsp_header_word    = head.header_word;
   assign rsp_dest_flow      = head.dest_flow;
   assign rsp_source_flow    = head.source_flow;
   assign rsp_sequence_value = head.sequence_value;
   assign rsp_ack_value      = head.ack_value;
   assign rsp_max_segment    = head.max_segment;
   assign rsp_fragment_word  = head.fragment_word;
   assign rsp_option_word    = head.option_word;
   assign rsp_present_mask   = head.present_mask;
   assign rsp_last_of_run    = head.last_of_run;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= ($clog2(RSP_DEPTH+1))'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      step_out.count == 2'd2 |->
         step_out.rec0.record_kind == KIND_OPTION && !step_out.rec0.last_of_run &&
         step_out.rec1.last_of_run)
      else $error("two-record item out of order");

   a_no_step_idle: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> step_out.count == 2'd0)
      else $error("records produced without an item");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

// ----- rtl/ftp_parse_core.sv -----
// ----------------------------------------------------------------------------
// ftp_parse_core
// Per-packet parse state and the combinational step that advances it by one
// byte, producing up to two records.
// ----------------------------------------------------------------------------
module ftp_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           data_byte,
   input  logic                 start_of_packet,
   input  logic                 end_of_packet,
   input  logic [15:0]          packet_length,
   output ftp_pkg::step_out_type step_out
);
   import ftp_pkg::*;

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_HDR    = 4'd1;
   localparam logic [3:0] PH_FIXED  = 4'd2;
   localparam logic [3:0] PH_OPTNUM = 4'd3;
   localparam logic [3:0] PH_OPTLEN = 4'd4;
   localparam logic [3:0] PH_OPTVAL = 4'd5;
   localparam logic [3:0] PH_SKIP   = 4'd6;
   localparam logic [3:0] PH_FRAG   = 4'd7;
   localparam logic [3:0] PH_DONE   = 4'd8;
   localparam logic [3:0] PH_OTHER  = 4'd9;

   localparam logic [7:0] MAIN_VERSION = 8'd2;
   localparam int         FLAG_SYN     = 1;
   localparam int         FLAG_ACK     = 2;
   localparam int         FLAG_BCST    = 4;
   localparam logic [9:0] WORD_BYTES   = 10'd4;
   localparam logic [7:0] FRAG_BYTES   = 8'd4;
   localparam logic [7:0] VALUE_BYTES  = 8'd2;
   localparam logic [7:0] LEN_OVERHEAD = 8'd2;

   // option numbers
   localparam logic [7:0] OPT_END     = 8'd0;
   localparam logic [7:0] OPT_VAL_A   = 8'd1;
   localparam logic [7:0] OPT_VAL_B   = 8'd2;
   localparam logic [7:0] OPT_VAL_C   = 8'd3;
   localparam logic [7:0] OPT_EMPTY_A = 8'd4;
   localparam logic [7:0] OPT_EMPTY_B = 8'd5;
   localparam logic [7:0] OPT_VAL_D   = 8'd7;
   localparam logic [7:0] OPT_VAL_E   = 8'd8;
   localparam logic [7:0] OPT_VAL_F   = 8'd9;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] offset_ff, offset_in;
   logic [9:0]  hdr_bytes_ff, hdr_bytes_in;
   logic        body_ff, body_in;
   logic [31:0] hdr_fields_ff, hdr_fields_in;
   logic [31:0] words_ff [6];
   logic [31:0] words_in [6];
   logic [31:0] opt_ff, opt_in;
   logic [7:0]  skip_ff, skip_in;
   logic [5:0]  mask_ff, mask_in;
   logic [15:0] held_ff, held_in;

   logic        active;
   logic        opt_emit;
   logic        found;
   logic [16:0] nxt;
   logic [4:0]  need;
   logic [4:0]  pend;
   logic [7:0]  num;
   rsp_rec_type opt_rec;
   rsp_rec_type sum_rec;

   // phase after the fixed words or an option, given the next byte index
   function automatic logic [3:0] after_phase(input logic [16:0] nx,
                                              input logic [9:0]  hb,
                                              input logic        body);
      logic [9:0] lim;
      lim = hb;
      if (body && hb >= WORD_BYTES) lim = hb - WORD_BYTES;
      if (nx < {7'd0, lim}) return PH_OPTNUM;
      else if (body) return PH_FRAG;
      else return PH_DONE;
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      hdr_bytes_in  = hdr_bytes_ff;
      body_in       = body_ff;
      hdr_fields_in = hdr_fields_ff;
      words_in      = words_ff;
      opt_in        = opt_ff;
      skip_in       = skip_ff;
      mask_in       = mask_ff;
      held_in       = held_ff;
      active        = 1'b0;
      opt_emit      = 1'b0;
      found         = 1'b0;
      need          = 5'd0;
      pend          = 5'd0;
      num           = 8'd0;
      nxt           = 17'd0;
      opt_rec       = '0;
      sum_rec       = '0;

      if (step_en) begin
         if (start_of_packet) begin
            phase_in      = PH_HDR;
            offset_in     = 16'd0;
            hdr_bytes_in  = 10'd0;
            body_in       = 1'b0;
            hdr_fields_in = 32'd0;
            words_in      = '{default: 32'd0};
            opt_in        = 32'd0;
            skip_in       = 8'd0;
            mask_in       = 6'd0;
            held_in       = packet_length;
            active        = 1'b1;
         end else if (phase_ff != PH_IDLE) begin
            active = 1'b1;
         end
      end

      if (active) begin
         nxt = {1'b0, offset_in} + 17'd1;
         unique case (phase_in)
            PH_HDR: begin
               if (offset_in == 16'd0) begin
                  hdr_fields_in = {data_byte, 24'd0};
                  if (data_byte != MAIN_VERSION) phase_in = PH_OTHER;
               end else if (offset_in == 16'd1) begin
                  hdr_fields_in[23:16] = data_byte;
                  hdr_bytes_in         = {data_byte, 2'b00};
                  body_in              = (held_in > {6'd0, hdr_bytes_in});
               end else if (offset_in == 16'd2) begin
                  hdr_fields_in[15:8] = data_byte;
               end else begin
                  hdr_fields_in[7:0] = data_byte;
                  phase_in = (hdr_bytes_in > WORD_BYTES) ? PH_FIXED : PH_DONE;
               end
            end
            PH_FIXED: begin
               // dest, source, seq, ack, mss in that order, as the flags ask
               need[0] = hdr_fields_in[8 + FLAG_ACK];
               need[3] = hdr_fields_in[8 + FLAG_ACK];
               need[1] = hdr_fields_in[8 + FLAG_SYN] | hdr_fields_in[8 + FLAG_BCST];
               need[4] = hdr_fields_in[8 + FLAG_SYN];
               need[2] = 1'b1;
               pend    = need & ~mask_in[4:0];
               for (int i = 0; i < 5; i++) begin
                  if (!found && pend[i]) begin
                     found       = 1'b1;
                     words_in[i] = {words_in[i][23:0], data_byte};
                     if (offset_in[1:0] == 2'd3) mask_in[i] = 1'b1;
                  end
               end
               if (!found) begin
                  phase_in = after_phase({1'b0, offset_in}, hdr_bytes_in, body_in);
                  skip_in  = FRAG_BYTES;
               end else if (offset_in[1:0] == 2'd3 &&
                            (need & ~mask_in[4:0]) == 5'd0) begin
                  phase_in = after_phase(nxt, hdr_bytes_in, body_in);
                  skip_in  = FRAG_BYTES;
               end
            end
            PH_OPTNUM: begin
               opt_in = {data_byte, 24'd0};
               if (data_byte == OPT_END) begin
                  opt_emit = 1'b1;
                  phase_in = after_phase(nxt, hdr_bytes_in, body_in);
                  skip_in  = FRAG_BYTES;
               end else begin
                  phase_in = PH_OPTLEN;
               end
            end
            PH_OPTLEN: begin
               num           = opt_in[31:24];
               opt_in[23:16] = data_byte;
               unique case (num) inside
                  OPT_VAL_A, OPT_VAL_B, OPT_VAL_C, OPT_VAL_D, OPT_VAL_E, OPT_VAL_F: begin
                     phase_in = PH_OPTVAL;
                     skip_in  = VALUE_BYTES;
                  end
                  OPT_EMPTY_A, OPT_EMPTY_B: begin
                     opt_emit = 1'b1;
                     phase_in = after_phase(nxt, hdr_bytes_in, body_in);
                     skip_in  = FRAG_BYTES;
                  end
                  default: begin
                     opt_emit = 1'b1;
                     if (data_byte > LEN_OVERHEAD) begin
                        phase_in = PH_SKIP;
                        skip_in  = data_byte - LEN_OVERHEAD;
                     end else begin
                        phase_in = after_phase(nxt, hdr_bytes_in, body_in);
                        skip_in  = FRAG_BYTES;
                     end
                  end
               endcase
            end
            PH_OPTVAL: begin
               opt_in[15:0] = {opt_in[7:0], data_byte};
               skip_in      = skip_in - 8'd1;
               if (skip_in == 8'd0) begin
                  opt_emit = 1'b1;
                  phase_in = after_phase(nxt, hdr_bytes_in, body_in);
                  skip_in  = FRAG_BYTES;
               end
            end
            PH_SKIP: begin
               skip_in = skip_in - 8'd1;
               if (skip_in == 8'd0) begin
                  phase_in = after_phase(nxt, hdr_bytes_in, body_in);
                  skip_in  = FRAG_BYTES;
               end
            end
            PH_FRAG: begin
               words_in[5] = {words_in[5][23:0], data_byte};
               skip_in     = skip_in - 8'd1;
               if (skip_in == 8'd0) begin
                  mask_in[5] = 1'b1;
                  phase_in   = PH_DONE;
               end
            end
            default: begin
            end
         endcase

         if (offset_in != 16'hFFFF) offset_in = offset_in + 16'd1;

         opt_rec.record_kind = KIND_OPTION;
         opt_rec.option_word = opt_in;
         opt_rec.last_of_run = !end_of_packet;

         if (end_of_packet) begin
            sum_rec.last_of_run = 1'b1;
            if (phase_in == PH_OTHER) begin
               sum_rec.record_kind = KIND_OTHER;
               sum_rec.header_word = {hdr_fields_in[31:24], 24'd0};
            end else begin
               sum_rec.record_kind    = KIND_SUMMARY;
               sum_rec.header_word    = hdr_fields_in;
               sum_rec.dest_flow      = mask_in[0] ? words_in[0] : 32'd0;
               sum_rec.source_flow    = mask_in[1] ? words_in[1] : 32'd0;
               sum_rec.sequence_value = mask_in[2] ? words_in[2] : 32'd0;
               sum_rec.ack_value      = mask_in[3] ? words_in[3] : 32'd0;
               sum_rec.max_segment    = mask_in[4] ? words_in[4] : 32'd0;
               sum_rec.fragment_word  = mask_in[5] ? words_in[5] : 32'd0;
               sum_rec.present_mask   = {phase_in != PH_DONE, mask_in};
            end
            // packet over: back to idle
            phase_in      = PH_IDLE;
            offset_in     = 16'd0;
            hdr_bytes_in  = 10'd0;
            body_in       = 1'b0;
            hdr_fields_in = 32'd0;
            words_in      = '{default: 32'd0};
            opt_in        = 32'd0;
            skip_in       = 8'd0;
            mask_in       = 6'd0;
            held_in       = 16'd0;
         end
      end
   end

   // option record goes first when a byte also ends the packet
   always_comb begin
      step_out = '0;
      if (opt_emit && active && end_of_packet) begin
         step_out.count = 2'd2;
         step_out.rec0  = opt_rec;
         step_out.rec1  = sum_rec;
      end else if (opt_emit) begin
         step_out.count = 2'd1;
         step_out.rec0  = opt_rec;
      end else if (active && end_of_packet) begin
         step_out.count = 2'd1;
         step_out.rec0  = sum_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         offset_ff     <= 16'd0;
         hdr_bytes_ff  <= 10'd0;
         body_ff       <= 1'b0;
         hdr_fields_ff <= 32'd0;
         words_ff      <= '{default: 32'd0};
         opt_ff        <= 32'd0;
         skip_ff       <= 8'd0;
         mask_ff       <= 6'd0;
         held_ff       <= 16'd0;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         hdr_bytes_ff  <= hdr_bytes_in;
         body_ff       <= body_in;
         hdr_fields_ff <= hdr_fields_in;
         words_ff      <= words_in;
         opt_ff        <= opt_in;
         skip_ff       <= skip_in;
         mask_ff       <= mask_in;
         held_ff       <= held_in;
      end
   end

endmodule

// ----- rtl/ftp_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// ftp_rsp_queue
// Result queue: takes up to two records a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
module ftp_rsp_queue #(
   parameter int DEPTH = ftp_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ftp_pkg::step_out_type push,
   input  logic                  pop,
   output ftp_pkg::rsp_rec_type  head,
   output logic                  not_empty,
   output logic                  room2,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   import ftp_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_rec_type       entry [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     wr_ptr_2nd;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_2nd = bump(wr_ptr_ff);
      wr_ptr_in  = wr_ptr_ff;
      if (push.count == 2'd1) wr_ptr_in = wr_ptr_2nd;
      else if (push.count == 2'd2) wr_ptr_in = bump(wr_ptr_2nd);
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry[wr_ptr_ff] <= push.rec0;
      if (push.count == 2'd2) entry[wr_ptr_2nd] <= push.rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = entry[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room2     = (count_ff <= CW'(DEPTH - 2));
   assign level     = count_ff;

endmodule
